// ===== design/dwrl_pkg.sv =====
// Shared widths, constants and types for the dual-window rate limiter.
// No dependencies; imported by the core and its checker.
`timescale 1ns / 1ps
`default_nettype none

package dwrl_pkg;

    // Request and result field widths
    localparam int ID_W    = 8;
    localparam int TIME_W  = 32;
    localparam int LIMIT_W = 16;
    localparam int MWIN_W  = 26;
    localparam int SWIN_W  = TIME_W;

    // Default table size
    localparam int NUM_CLIENTS_DEF = 256;

    // Register port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index, taken from the word address bit paddr[2]
    localparam logic REG_MINUTE_LIMIT = 1'b0;
    localparam logic REG_SECOND_LIMIT = 1'b1;

    // Limit values after reset
    localparam logic [LIMIT_W-1:0] MINUTE_LIMIT_RST = 16'd60;
    localparam logic [LIMIT_W-1:0] SECOND_LIMIT_RST = 16'd10;

    // Divide by 60 as (t >> 2) / 15: multiply the 30-bit quotient of t / 4
    // by ceil(2^34 / 15) and keep the bits above 34.
    localparam int                DIV15_IN_W  = TIME_W - 2;
    localparam int                DIV15_K_W   = 31;
    localparam int                DIV15_SHIFT = 34;
    localparam int                DIV15_PROD_W = DIV15_IN_W + DIV15_K_W;
    localparam logic [DIV15_K_W-1:0] DIV15_MAGIC = 31'h4444_4445;

    // One client's table entry
    typedef struct packed {
        logic [MWIN_W-1:0]  mwin;
        logic [LIMIT_W-1:0] mcnt;
        logic [SWIN_W-1:0]  swin;
        logic [LIMIT_W-1:0] scnt;
    } t_entry;

endpackage : dwrl_pkg

`default_nettype wire

// ===== design/dual_window_rate_limiter_core.sv =====
// Dual-window (minute and second) per-client rate limiter core.
// Depends on dwrl_pkg for widths, register codes and the table entry type.
`timescale 1ns / 1ps
`default_nettype none

// Takes one request per cycle while o_in_stall is low and returns one
// allowed/refused result per request, in order, from the output register
// after the stage 1 and stage 2 registers. The first stage divides the time
// by 60 with a reciprocal multiply while the client's entry is read from the
// table; the second stage compares windows and counts against the limits,
// writes the entry back and feeds it forward to a following request for the
// same client, so back-to-back requests from one client are judged correctly.
// The table holds one entry per client (up to 256) with a valid bit each,
// all cleared together at reset; there is no clearing pass. The whole
// pipeline holds only while a result sits in the output register and is
// stalled. Limits must be written through the register port only while no
// request is in flight; the block does not enforce this. per_minute_limit is
// at byte address 0, per_second_limit at 4.
module dual_window_rate_limiter_core #(
    parameter int NUM_CLIENTS = dwrl_pkg::NUM_CLIENTS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // request channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [dwrl_pkg::ID_W-1:0]       i_client_id,
    input  wire logic [dwrl_pkg::TIME_W-1:0]     i_now_seconds,
    // result channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic                                 o_allowed,
    // register port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [dwrl_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [dwrl_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dwrl_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import dwrl_pkg::*;

    localparam int TBL_DEPTH = (NUM_CLIENTS < (2 ** ID_W)) ? NUM_CLIENTS : (2 ** ID_W);
    localparam int IDX_W     = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

    // ---------------- registers ----------------
    logic [LIMIT_W-1:0] r_minute_limit;
    logic [LIMIT_W-1:0] r_second_limit;

    t_entry             r_tbl [TBL_DEPTH];
    logic               r_vld [TBL_DEPTH];

    logic               r_s1_valid;
    logic [ID_W-1:0]    r_s1_id;
    logic [TIME_W-1:0]  r_s1_now;

    logic               r_s2_valid;
    logic               r_s2_in_range;
    logic [IDX_W-1:0]   r_s2_idx;
    logic [MWIN_W-1:0]  r_s2_mwin;
    logic [SWIN_W-1:0]  r_s2_swin;
    t_entry             r_s2_mem;
    logic               r_s2_vld;
    logic               r_s2_hit;
    t_entry             r_s2_fwd;

    logic               r_out_valid;
    logic               r_out_allowed;

    // ---------------- combinational signals ----------------
    logic                    adv;
    logic                    cfg_wr;
    logic [IDX_W-1:0]        s1_idx;
    logic                    s1_in_range;
    logic [DIV15_PROD_W-1:0] s1_prod;
    logic [MWIN_W-1:0]       s1_mwin;
    t_entry                  s2_cur;
    logic [LIMIT_W-1:0]      s2_mcnt;
    logic [LIMIT_W-1:0]      s2_scnt;
    logic                    n_allowed;
    logic                    wr_en;
    t_entry                  wr_data;
    logic                    wr_hit;

    // Pipeline moves unless a result is held in the output register and stalled
    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = !adv;

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minute_limit <= MINUTE_LIMIT_RST;
            r_second_limit <= SECOND_LIMIT_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_MINUTE_LIMIT: r_minute_limit <= pwdata[LIMIT_W-1:0];
                REG_SECOND_LIMIT: r_second_limit <= pwdata[LIMIT_W-1:0];
                default:          r_minute_limit <= r_minute_limit;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MINUTE_LIMIT: prdata = APB_DATA_W'(r_minute_limit);
            REG_SECOND_LIMIT: prdata = APB_DATA_W'(r_second_limit);
            default:          prdata = '0;
        endcase
    end

    // ---------------- stage 1: input register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_id  <= i_client_id;
            r_s1_now <= i_now_seconds;
        end
    end

    // Minute index: (now / 4) * ceil(2^34 / 15) >> 34, kept to 26 bits
    assign s1_prod = DIV15_PROD_W'(r_s1_now[TIME_W-1:2]) * DIV15_PROD_W'(DIV15_MAGIC);
    assign s1_mwin = s1_prod[DIV15_SHIFT +: MWIN_W];

    assign s1_idx      = r_s1_id[IDX_W-1:0];
    assign s1_in_range = (32'(r_s1_id) < 32'(NUM_CLIENTS));

    // Write from stage 2 lands on the same edge as the stage 1 read
    assign wr_hit = wr_en && (r_s2_idx == s1_idx);

    // ---------------- client table ----------------
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_tbl[r_s2_idx] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_mem <= r_tbl[s1_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TBL_DEPTH; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (wr_en) begin
            r_vld[r_s2_idx] <= 1'b1;
        end
    end

    // ---------------- stage 2 registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_in_range <= s1_in_range;
            r_s2_idx      <= s1_idx;
            r_s2_mwin     <= s1_mwin;
            r_s2_swin     <= r_s1_now;
            r_s2_vld      <= wr_hit || r_vld[s1_idx];
            r_s2_hit      <= wr_hit;
            r_s2_fwd      <= wr_data;
        end
    end

    // ---------------- stage 2: judge and update ----------------
    always_comb begin
        // current entry: forwarded, stored, or the reset value
        if (r_s2_hit) begin
            s2_cur = r_s2_fwd;
        end else if (r_s2_vld) begin
            s2_cur = r_s2_mem;
        end else begin
            s2_cur = '0;
        end

        // a changed window restarts its count
        s2_mcnt = (s2_cur.mwin == r_s2_mwin) ? s2_cur.mcnt : '0;
        s2_scnt = (s2_cur.swin == r_s2_swin) ? s2_cur.scnt : '0;

        n_allowed = r_s2_in_range && (s2_mcnt < r_minute_limit)
                    && (s2_scnt < r_second_limit);

        // counts stay below a 16-bit limit, so +1 cannot wrap
        wr_data.mwin = r_s2_mwin;
        wr_data.swin = r_s2_swin;
        wr_data.mcnt = n_allowed ? s2_mcnt + LIMIT_W'(1) : s2_mcnt;
        wr_data.scnt = n_allowed ? s2_scnt + LIMIT_W'(1) : s2_scnt;

        wr_en = adv && r_s2_valid && r_s2_in_range;
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_allowed <= n_allowed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_allowed   = r_out_allowed;

endmodule : dual_window_rate_limiter_core

`default_nettype wire

// ===== design/dwrl_checker.sv =====
// Port-level checks for the dual-window rate limiter core, with its bind.
// Depends on dwrl_pkg and on dual_window_rate_limiter_core.
`timescale 1ns / 1ps
`default_nettype none

module dwrl_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_stall,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_stall,
    input wire logic                            o_allowed,
    input wire logic                            psel,
    input wire logic                            penable,
    input wire logic                            pwrite,
    input wire logic [dwrl_pkg::APB_ADDR_W-1:0] paddr,
    input wire logic [dwrl_pkg::APB_DATA_W-1:0] pwdata,
    input wire logic [dwrl_pkg::APB_DATA_W-1:0] prdata
);
    import dwrl_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_allowed))
        else $error("stalled result changed");

    // Requests are only held off while a result waits on a stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("request stalled without a held result");

    // A request accepted while the pipeline keeps moving shows its result on o_out_valid
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 !o_in_stall ##1 !o_in_stall |=> o_out_valid)
        else $error("result missing after request");

    // A limit reads back as written
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite) ##1 (psel && !pwrite && paddr[2] == $past(paddr[2]))
        |-> prdata == APB_DATA_W'($past(pwdata[LIMIT_W-1:0])))
        else $error("limit read-back mismatch");

endmodule : dwrl_checker

bind dual_window_rate_limiter_core dwrl_checker u_dwrl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_allowed   (o_allowed),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
);

`default_nettype wire
